>>> rtl/tsg_pkg.sv
`default_nettype none
package tsg_pkg;

    typedef enum logic [1:0] {
        MODE_STEP   = 2'd0,
        MODE_SINE   = 2'd1,
        MODE_SQUARE = 2'd2,
        MODE_ZERO   = 2'd3
    } t_mode;

    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE  = 3'd1;
    localparam logic [2:0] REG_PERIOD     = 3'd2;
    localparam logic [2:0] REG_ACTIVATION = 3'd3;
    localparam logic [2:0] REG_STEP_LEVEL = 3'd4;
    localparam logic [2:0] REG_DUTY       = 3'd5;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PER_W  = 16;
    localparam int unsigned AMP_W  = 15;
    localparam int unsigned DUTY_W = 9;
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned MAG_W  = 15;

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic valid;
        logic step_on;
        logic sq_on;
    } t_flags;

    // quarter-wave sine entry, unsigned Q0.15, taylor series to the x^11 term
    function automatic logic [MAG_W-1:0] quarter_entry(input int unsigned k,
                                                       input int unsigned shift);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x = (HALF_PI_Q30 * 64'(k)) >> shift;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int n = 1; n <= 5; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32767) begin
            sum = 32767;
        end
        return sum[MAG_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/tsg_mod_pipe.sv
`default_nettype none
module tsg_mod_pipe
    import tsg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic              i_step_on,
    input  wire logic [TIME_W-1:0] i_time,
    input  wire logic [PER_W-1:0]  i_period,
    output      logic              o_valid,
    output      logic              o_step_on,
    output      logic [PER_W-1:0]  o_rem
);

    // one restoring remainder step per stage, msb of time first
    logic              r_v [0:TIME_W-1];
    logic              r_s [0:TIME_W-1];
    logic [TIME_W-1:0] r_t [0:TIME_W-1];
    logic [PER_W-1:0]  r_r [0:TIME_W-1];

    for (genvar g = 0; g < TIME_W; g++) begin : g_stage
        logic              v_in;
        logic              s_in;
        logic [TIME_W-1:0] t_in;
        logic [PER_W-1:0]  rem_in;
        logic [PER_W:0]    shifted;
        logic [PER_W-1:0]  n_rem;

        if (g == 0) begin : g_first
            assign v_in   = i_valid;
            assign s_in   = i_step_on;
            assign t_in   = i_time;
            assign rem_in = '0;
        end else begin : g_rest
            assign v_in   = r_v[g-1];
            assign s_in   = r_s[g-1];
            assign t_in   = r_t[g-1];
            assign rem_in = r_r[g-1];
        end

        always_comb begin
            shifted = {rem_in, t_in[TIME_W-1-g]};
            if (shifted >= {1'b0, i_period}) begin
                n_rem = PER_W'(shifted - {1'b0, i_period});
            end else begin
                n_rem = shifted[PER_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
            if (i_en) begin
                r_s[g] <= s_in;
                r_t[g] <= t_in;
                r_r[g] <= n_rem;
            end
        end
    end

    assign o_valid   = r_v[TIME_W-1];
    assign o_step_on = r_s[TIME_W-1];
    assign o_rem     = r_r[TIME_W-1];

endmodule
`default_nettype wire

>>> rtl/tsg_phase_pipe.sv
`default_nettype none
module tsg_phase_pipe
    import tsg_pkg::*;
#(
    parameter int unsigned PHASE_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic                  i_step_on,
    input  wire logic [PER_W-1:0]      i_rem,
    input  wire logic [PER_W-1:0]      i_period,
    input  wire logic [DUTY_W-1:0]     i_duty,
    output      t_flags                o_flags,
    output      logic [PHASE_BITS-1:0] o_phase
);

    t_flags                r_f [0:PHASE_BITS-1];
    logic [PER_W-1:0]      r_r [0:PHASE_BITS-1];
    logic [PHASE_BITS-1:0] r_q [0:PHASE_BITS-1];

    logic sq_on;
    // tm*256 < duty*period
    assign sq_on = ({i_rem, 8'd0} < ((PER_W + DUTY_W)'(i_duty) * (PER_W + DUTY_W)'(i_period)));

    for (genvar g = 0; g < PHASE_BITS; g++) begin : g_stage
        t_flags                f_in;
        logic [PER_W-1:0]      rem_in;
        logic [PHASE_BITS-1:0] q_in;
        logic [PER_W:0]        shifted;
        logic                  qb;
        logic [PER_W-1:0]      n_rem;

        if (g == 0) begin : g_first
            assign f_in   = '{valid: i_valid, step_on: i_step_on, sq_on: sq_on};
            assign rem_in = i_rem;
            assign q_in   = '0;
        end else begin : g_rest
            assign f_in   = r_f[g-1];
            assign rem_in = r_r[g-1];
            assign q_in   = r_q[g-1];
        end

        always_comb begin
            shifted = {rem_in, 1'b0};
            qb = (shifted >= {1'b0, i_period});
            if (qb) begin
                n_rem = PER_W'(shifted - {1'b0, i_period});
            end else begin
                n_rem = shifted[PER_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f[g].valid <= 1'b0;
            end else if (i_en) begin
                r_f[g].valid <= f_in.valid;
            end
            if (i_en) begin
                r_f[g].step_on <= f_in.step_on;
                r_f[g].sq_on   <= f_in.sq_on;
                r_r[g]         <= n_rem;
                r_q[g]         <= {q_in[PHASE_BITS-2:0], qb};
            end
        end
    end

    assign o_flags = r_f[PHASE_BITS-1];
    assign o_phase = r_q[PHASE_BITS-1];

endmodule
`default_nettype wire

>>> rtl/tsg_wave.sv
`default_nettype none
module tsg_wave
    import tsg_pkg::*;
#(
    parameter int unsigned PHASE_BITS   = 10,
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_flags                i_flags,
    input  wire logic [PHASE_BITS-1:0] i_phase,
    input  wire t_mode                 i_mode,
    input  wire logic [AMP_W-1:0]      i_amplitude,
    input  wire logic [OUT_W-1:0]      i_step_level,
    output      logic                  o_valid,
    output      logic [OUT_W-1:0]      o_sample
);

    localparam int unsigned SHIFT = PHASE_BITS - 2;
    localparam int unsigned QTR   = 1 << SHIFT;
    localparam int unsigned K_W   = PHASE_BITS - 1;
    localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam longint SAT_LO = -SAT_HI - 64'sd1;

    logic [MAG_W-1:0] rom [0:QTR];
    for (genvar g = 0; g <= QTR; g++) begin : g_rom
        assign rom[g] = quarter_entry(g, SHIFT);
    end

    // stage a: fold phase into the quarter table
    t_flags           r_fa;
    logic             r_nega;
    logic [K_W-1:0]   r_k;
    logic [SHIFT-1:0] rr;
    logic [K_W-1:0]   n_k;

    assign rr = i_phase[SHIFT-1:0];
    always_comb begin
        if (i_phase[SHIFT]) begin
            n_k = K_W'(QTR) - K_W'(rr);
        end else begin
            n_k = K_W'(rr);
        end
    end

    // stage b: table read
    t_flags           r_fb;
    logic             r_negb;
    logic [MAG_W-1:0] r_mag;

    // stage c: scale by amplitude
    t_flags           r_fc;
    logic             r_negc;
    logic [OUT_W-1:0] r_m;
    logic [2*MAG_W:0] prod;

    assign prod = (2*MAG_W+1)'(i_amplitude) * (2*MAG_W+1)'(r_mag) + (2*MAG_W+1)'(16384);

    // stage d: mode select and saturate
    logic              r_vd;
    logic [OUT_W-1:0]  r_out;
    logic signed [32:0] v;
    logic signed [32:0] vs;

    always_comb begin
        case (i_mode)
            MODE_STEP:   v = r_fc.step_on ? 33'(signed'(i_step_level)) : '0;
            MODE_SINE:   v = r_negc ? -33'(r_m) : 33'(r_m);
            MODE_SQUARE: v = r_fc.sq_on ? 33'(i_amplitude) : '0;
            default:     v = '0;
        endcase
        if (v > 33'(SAT_HI)) begin
            vs = 33'(SAT_HI);
        end else if (v < 33'(SAT_LO)) begin
            vs = 33'(SAT_LO);
        end else begin
            vs = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa.valid <= 1'b0;
            r_fb.valid <= 1'b0;
            r_fc.valid <= 1'b0;
            r_vd       <= 1'b0;
        end else if (i_en) begin
            r_fa.valid <= i_flags.valid;
            r_fb.valid <= r_fa.valid;
            r_fc.valid <= r_fb.valid;
            r_vd       <= r_fc.valid;
        end
        if (i_en) begin
            r_fa.step_on <= i_flags.step_on;
            r_fa.sq_on   <= i_flags.sq_on;
            r_nega       <= i_phase[PHASE_BITS-1];
            r_k          <= n_k;
            r_fb.step_on <= r_fa.step_on;
            r_fb.sq_on   <= r_fa.sq_on;
            r_negb       <= r_nega;
            r_mag        <= rom[r_k];
            r_fc.step_on <= r_fb.step_on;
            r_fc.sq_on   <= r_fb.sq_on;
            r_negc       <= r_negb;
            r_m          <= prod[15 +: OUT_W];
            r_out        <= vs[OUT_W-1:0];
        end
    end

    assign o_valid  = r_vd;
    assign o_sample = r_out;

endmodule
`default_nettype wire

>>> rtl/test_signal_generator.sv
// throughput: one beat per cycle while the output is not stalled; 32 remainder
// stages and PHASE_BITS phase stages, one quotient bit per phase stage, then
// fold, table, scale and select stages
// reset: synchronous active low; clears all valid bits and loads the
// register defaults (step mode, amplitude 256, period 1, step level 256, duty 256)
`default_nettype none
module test_signal_generator
    import tsg_pkg::*;
#(
    parameter int unsigned PHASE_BITS   = 10,
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire logic [TIME_W-1:0] i_time_index,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      logic [OUT_W-1:0]  o_sample,
    input  wire logic              i_cfg_valid,
    output      logic              o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);

    t_mode              r_mode;
    logic [AMP_W-1:0]   r_amplitude;
    logic [PER_W-1:0]   r_period;
    logic [TIME_W-1:0]  r_activation;
    logic [OUT_W-1:0]   r_step_level;
    logic [DUTY_W-1:0]  r_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_STEP;
            r_amplitude  <= AMP_W'(256);
            r_period     <= PER_W'(1);
            r_activation <= '0;
            r_step_level <= OUT_W'(256);
            r_duty       <= DUTY_W'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:       r_mode       <= t_mode'(i_cfg_data[1:0]);
                REG_AMPLITUDE:  r_amplitude  <= i_cfg_data[AMP_W-1:0];
                REG_PERIOD:     r_period     <= i_cfg_data[PER_W-1:0];
                REG_ACTIVATION: r_activation <= i_cfg_data;
                REG_STEP_LEVEL: r_step_level <= i_cfg_data[OUT_W-1:0];
                REG_DUTY:       r_duty       <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // a zero period acts as one
    logic [PER_W-1:0] per;
    assign per = (r_period == '0) ? PER_W'(1) : r_period;

    // whole pipe advances unless the output register holds a stalled beat
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic             m_valid;
    logic             m_step_on;
    logic [PER_W-1:0] m_rem;

    tsg_mod_pipe u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_step_on (i_time_index >= r_activation),
        .i_time    (i_time_index),
        .i_period  (per),
        .o_valid   (m_valid),
        .o_step_on (m_step_on),
        .o_rem     (m_rem)
    );

    t_flags                p_flags;
    logic [PHASE_BITS-1:0] p_phase;

    tsg_phase_pipe #(.PHASE_BITS(PHASE_BITS)) u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (m_valid),
        .i_step_on (m_step_on),
        .i_rem     (m_rem),
        .i_period  (per),
        .i_duty    (r_duty),
        .o_flags   (p_flags),
        .o_phase   (p_phase)
    );

    tsg_wave #(.PHASE_BITS(PHASE_BITS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_wave (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_flags      (p_flags),
        .i_phase      (p_phase),
        .i_mode       (r_mode),
        .i_amplitude  (r_amplitude),
        .i_step_level (r_step_level),
        .o_valid      (o_valid),
        .o_sample     (o_sample)
    );

endmodule
`default_nettype wire

>>> rtl/tsg_checker.sv
`default_nettype none
module tsg_checker
    import tsg_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_stall,
    input wire logic             o_stall,
    input wire logic             o_valid,
    input wire logic [OUT_W-1:0] o_sample,
    input wire logic             o_cfg_ready
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("stalled output beat changed");

    // input side stalls only behind a stalled output beat
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without output backpressure");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind test_signal_generator tsg_checker u_tsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .o_sample    (o_sample),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire

>>> test/tsg_checker.sv
`default_nettype none
module tsg_scoreboard
    import tsg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [TIME_W-1:0] i_time_index,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [OUT_W-1:0]  i_sample,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    output      int                o_errors,
    output      int                o_pending,
    output      int                o_checked
);

    localparam int unsigned QTR_SHIFT = 8;
    localparam int unsigned QTR_LEN   = 1 << QTR_SHIFT;

    t_mode                     wave_mode;
    logic [AMP_W-1:0]          peak;
    logic [PER_W-1:0]          wave_period;
    logic [TIME_W-1:0]         step_time;
    logic signed [OUT_W-1:0]   step_value;
    logic [DUTY_W-1:0]         duty_frac;

    logic [MAG_W-1:0]          sine_rom [0:QTR_LEN];
    logic [OUT_W-1:0]          sample_fifo [$];

    // quarter-wave magnitude via truncated taylor series in Q2.30
    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned part;
        longint          acc;
        ang = (64'd1686629713 * 64'(k)) >> QTR_SHIFT;
        ang_sq = (ang * ang) >> 30;
        part = ang;
        acc = longint'(ang);
        for (int n = 1; n <= 5; n++) begin
            part = (part * ang_sq) >> 30;
            part = part / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc = acc - longint'(part);
            else acc = acc + longint'(part);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 16384) >>> 15;
        if (acc > 32767) acc = 32767;
        return acc[MAG_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] waveform_at(input logic [TIME_W-1:0] t);
        longint unsigned per;
        longint unsigned tmod;
        longint unsigned phase;
        longint unsigned mag;
        longint unsigned scaled;
        int unsigned     quad;
        int unsigned     rem;
        longint          val;
        per = (wave_period == 0) ? 1 : 64'(wave_period);
        tmod = 64'(t) % per;
        val = 0;
        case (wave_mode)
            MODE_STEP: begin
                if (t >= step_time) val = longint'(step_value);
            end
            MODE_SINE: begin
                phase = (tmod << 10) / per;
                quad = int'(phase >> QTR_SHIFT) & 3;
                rem = int'(phase) & (QTR_LEN - 1);
                mag = 64'(sine_rom[(quad & 1) ? QTR_LEN - rem : rem]);
                scaled = (64'(peak) * mag + 16384) >> 15;
                val = (quad & 2) ? -longint'(scaled) : longint'(scaled);
            end
            MODE_SQUARE: begin
                if (tmod * 256 < 64'(duty_frac) * per) val = longint'(peak);
            end
            default: val = 0;
        endcase
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        return val[OUT_W-1:0];
    endfunction

    initial begin
        for (int k = 0; k <= QTR_LEN; k++) sine_rom[k] = sine_mag(k);
    end

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            wave_mode   <= MODE_STEP;
            peak        <= 15'd256;
            wave_period <= 16'd1;
            step_time   <= '0;
            step_value  <= 16'sd256;
            duty_frac   <= 9'd256;
            sample_fifo.delete();
            o_errors    <= 0;
            o_checked   <= 0;
            o_pending   <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:       wave_mode   <= t_mode'(i_cfg_data[1:0]);
                    REG_AMPLITUDE:  peak        <= i_cfg_data[AMP_W-1:0];
                    REG_PERIOD:     wave_period <= i_cfg_data[PER_W-1:0];
                    REG_ACTIVATION: step_time   <= i_cfg_data;
                    REG_STEP_LEVEL: step_value  <= i_cfg_data[OUT_W-1:0];
                    REG_DUTY:       duty_frac   <= i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) sample_fifo.push_back(waveform_at(i_time_index));
            if (i_out_valid && !i_out_stall) begin
                if (sample_fifo.size() == 0) begin
                    $display("%0t: unexpected sample beat, actual %h", $time, i_sample);
                    o_errors <= o_errors + 1;
                end else begin
                    want = sample_fifo.pop_front();
                    o_checked <= o_checked + 1;
                    if (want !== i_sample) begin
                        $display("%0t: sample mismatch, expected %h actual %h",
                                 $time, want, i_sample);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= sample_fifo.size();
        end
    end

endmodule
`default_nettype wire

>>> test/tb.sv
`default_nettype none
module tb;
    import tsg_pkg::*;

    localparam int LATENCY  = 46;
    localparam int WDOG_MAX = 5000;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [TIME_W-1:0] i_time_index;
    logic              o_valid;
    logic              i_stall;
    logic [OUT_W-1:0]  o_sample;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [31:0]       i_cfg_data;

    int errors;
    int pending;
    int checked;
    int items_sent;
    int phases;
    int idle_cycles;
    int stall_left;
    logic stall_level;
    logic [31:0] cur_period;
    logic [31:0] cur_act;

    test_signal_generator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_time_index(i_time_index),
        .o_valid(o_valid), .i_stall(i_stall), .o_sample(o_sample),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    tsg_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_time_index(i_time_index),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_sample(o_sample),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure: bursts of stall and of free flow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
            stall_level <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_level = ($urandom_range(0, 2) == 0);
            i_stall <= stall_level;
            stall_left <= stall_level ? gap_len() : $urandom_range(0, 30);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n)
            idle_cycles <= 0;
        else if ((i_valid && !o_stall) || (o_valid && !i_stall)
                 || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_PERIOD) cur_period = (data[15:0] == 0) ? 1 : 32'(data[15:0]);
        if (idx == REG_ACTIVATION) cur_act = data;
    endtask

    task automatic send_time(input logic [31:0] t);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_time_index <= t;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // pending is registered, so step past the last beat before polling it
    task automatic drain();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        phases++;
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1, 2: return $urandom_range(0, 4 * cur_period);
            3: return cur_act + $urandom_range(0, 4) - 2;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 3 * cur_period);
        endcase
    endfunction

    function automatic logic [31:0] pick_amp();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32767;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(1, 65535);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_time_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MODE;
        i_cfg_data = '0;
        items_sent = 0;
        phases = 0;
        cur_period = 1;
        cur_act = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults after reset
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        drain();

        // step edges at the extremes of the level
        write_reg(REG_ACTIVATION, 32'd1000);
        write_reg(REG_STEP_LEVEL, 32'h0000_8000);
        send_time(32'd999);
        send_time(32'd1000);
        send_time(32'd1001);
        drain();
        write_reg(REG_STEP_LEVEL, 32'h0000_7FFF);
        send_time(32'hFFFF_FFFF);
        drain();
        write_reg(REG_ACTIVATION, 32'hFFFF_FFFF);
        send_time(32'hFFFF_FFFE);
        send_time(32'hFFFF_FFFF);
        drain();

        // one full sine turn at full amplitude, all quadrants
        write_reg(REG_MODE, 32'(MODE_SINE));
        write_reg(REG_AMPLITUDE, 32'd32767);
        write_reg(REG_PERIOD, 32'd8);
        for (int t = 0; t < 8; t++) send_time(32'(t));
        drain();

        // square with half duty, then duty above full scale, zero duty, then zero period
        write_reg(REG_MODE, 32'(MODE_SQUARE));
        write_reg(REG_PERIOD, 32'd4);
        write_reg(REG_DUTY, 32'd128);
        for (int t = 0; t < 4; t++) send_time(32'(t));
        drain();
        write_reg(REG_DUTY, 32'd511);
        send_time(32'd3);
        drain();
        write_reg(REG_DUTY, 32'd0);
        send_time(32'd0);
        drain();
        write_reg(REG_PERIOD, 32'd0);
        write_reg(REG_DUTY, 32'd256);
        send_time(32'd12345);
        drain();

        // unused mode and writes to unused indexes
        write_reg(REG_MODE, 32'(MODE_ZERO));
        write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_B, 32'h1234_5678);
        send_time(32'd7);
        drain();

        while (items_sent < 1700) begin
            write_reg(REG_MODE, $urandom_range(0, 3));
            write_reg(REG_AMPLITUDE, pick_amp());
            write_reg(REG_PERIOD, pick_period());
            write_reg(REG_ACTIVATION, ($urandom_range(0, 3) == 0) ? $urandom()
                                                                 : $urandom_range(0, 2000));
            write_reg(REG_STEP_LEVEL, $urandom());
            write_reg(REG_DUTY, ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
                                                            : $urandom_range(0, 256));
            repeat ($urandom_range(40, 120)) send_time(pick_time());
            drain();
        end

        $display("ran %0d time indexes over %0d register settings, %0d samples checked",
                 items_sent, phases, checked);
        $display("covered step, sine, square and zero modes with random stalls and gaps");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
